FILE: rtl/krt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg
// Shared types and constants of the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int KEY_W    = 27;
  localparam int AGE_W    = 7;
  localparam int SLOT_W   = 6;
  localparam int CNT_W    = 7;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] YOUNG_LIMIT_RST = 7'd18;
  localparam logic [CFG_W-1:0] OLD_LIMIT_RST   = 7'd35;

  localparam logic [CFG_IDX_W-1:0] CFG_YOUNG_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OLD_LIMIT   = 1'd1;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_HIST   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_DUPLICATE = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } fsm_state_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } entry_t;

endpackage

FILE: rtl/krt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module krt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/keyed_record_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table_unit
// Record table with insert, delete, lookup and age histogram, one entry
// scanned per cycle out of a single RAM.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  in       | start, busy        | in_kind, in_id_key, in_age
//  out      | out_valid (strobe) | out_status, out_slot, out_found_age,
//           |                    | out_count_young/middle/old/largest
//  cfg      | cfg_we             | cfg_index, cfg_wdata
//
// each transaction runs from accept through a scan that issues one RAM read per
// entry, a drain state for the last read data and a done state for the write
// back; the result strobe is registered and shows as the unit returns to idle
// after reset a clearing pass zeroes every RAM entry, busy high
// results cannot be stalled: out_valid is high for exactly one cycle
// ----------------------------------------------------------------------------
module keyed_record_table_unit
  import krt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           in_kind,
  input  logic [KEY_W-1:0]     in_id_key,
  input  logic [AGE_W-1:0]     in_age,
  output logic                 out_valid,
  output logic [1:0]           out_status,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [AGE_W-1:0]     out_found_age,
  output logic [CNT_W-1:0]     out_count_young,
  output logic [CNT_W-1:0]     out_count_middle,
  output logic [CNT_W-1:0]     out_count_old,
  output logic [CNT_W-1:0]     out_count_largest,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);

  fsm_state_t state_r, state_nxt;

  logic [AW-1:0]    scan_r, scan_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  kind_t            kind_r, kind_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [AGE_W-1:0] age_r, age_nxt;
  logic             free_hit_r, free_hit_nxt;
  logic [AW-1:0]    free_idx_r, free_idx_nxt;
  logic             match_hit_r, match_hit_nxt;
  logic [AW-1:0]    match_idx_r, match_idx_nxt;
  logic [AGE_W-1:0] match_age_r, match_age_nxt;
  logic [CW-1:0]    cnt_y_r, cnt_y_nxt;
  logic [CW-1:0]    cnt_m_r, cnt_m_nxt;
  logic [CW-1:0]    cnt_o_r, cnt_o_nxt;
  logic [CFG_W-1:0] young_r, young_nxt;
  logic [CFG_W-1:0] old_r, old_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          status_r, status_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [AGE_W-1:0] fage_r, fage_nxt;
  logic [CNT_W-1:0] oy_r, oy_nxt, om_r, om_nxt, oo_r, oo_nxt, ol_r, ol_nxt;

  logic          accept;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;
  logic [CW-1:0] largest;
  logic [AW-1:0] rd_idx;

  assign accept = start && (state_r == S_IDLE);

  // scan address wraps to zero after the last entry
  assign rd_idx = (scan_r == '0) ? LAST_ADDR : scan_r - AW'(1);

  krt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_r),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (scan_r == LAST_ADDR) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_r == LAST_ADDR) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs: busy and the RAM write port
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = scan_r;
    ram_wdata = '0;
    case (state_r)
      S_CLEAR: ram_we = 1'b1;
      S_IDLE:  busy = 1'b0;
      S_SCAN:  ;
      S_DRAIN: ;
      S_DONE: begin
        if (kind_r == KIND_INSERT && free_hit_r && !match_hit_r) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx_r;
          ram_wdata = '{vld: 1'b1, key: key_r, age: age_r};
        end else if (kind_r == KIND_DELETE && match_hit_r) begin
          ram_we    = 1'b1;
          ram_waddr = match_idx_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    largest = cnt_y_r;
    if (cnt_m_r > largest) largest = cnt_m_r;
    if (cnt_o_r > largest) largest = cnt_o_r;
  end

  // datapath
  always_comb begin
    scan_nxt      = scan_r;
    rd_vld_nxt    = 1'b0;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    age_nxt       = age_r;
    free_hit_nxt  = free_hit_r;
    free_idx_nxt  = free_idx_r;
    match_hit_nxt = match_hit_r;
    match_idx_nxt = match_idx_r;
    match_age_nxt = match_age_r;
    cnt_y_nxt     = cnt_y_r;
    cnt_m_nxt     = cnt_m_r;
    cnt_o_nxt     = cnt_o_r;
    young_nxt     = young_r;
    old_nxt       = old_r;
    out_valid_nxt = 1'b0;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    fage_nxt      = fage_r;
    oy_nxt        = oy_r;
    om_nxt        = om_r;
    oo_nxt        = oo_r;
    ol_nxt        = ol_r;

    if (cfg_we) begin
      if (cfg_index == CFG_YOUNG_LIMIT) young_nxt = cfg_wdata;
      if (cfg_index == CFG_OLD_LIMIT)   old_nxt   = cfg_wdata;
    end

    if (state_r == S_CLEAR || state_r == S_SCAN) begin
      scan_nxt   = (scan_r == LAST_ADDR) ? '0 : scan_r + AW'(1);
      rd_vld_nxt = (state_r == S_SCAN);
    end

    if (accept) begin
      kind_nxt      = kind_t'(in_kind);
      key_nxt       = in_id_key;
      age_nxt       = in_age;
      scan_nxt      = '0;
      free_hit_nxt  = 1'b0;
      free_idx_nxt  = '0;
      match_hit_nxt = 1'b0;
      match_idx_nxt = '0;
      match_age_nxt = '0;
      cnt_y_nxt     = '0;
      cnt_m_nxt     = '0;
      cnt_o_nxt     = '0;
    end

    // read data belongs to the address issued in the cycle before
    if (rd_vld_r) begin
      if (!ram_rdata.vld && !free_hit_r) begin
        free_hit_nxt = 1'b1;
        free_idx_nxt = rd_idx;
      end
      if (ram_rdata.vld && ram_rdata.key == key_r && !match_hit_r) begin
        match_hit_nxt = 1'b1;
        match_idx_nxt = rd_idx;
        match_age_nxt = ram_rdata.age;
      end
      if (ram_rdata.vld) begin
        if (ram_rdata.age <= young_r)    cnt_y_nxt = cnt_y_r + CW'(1);
        else if (ram_rdata.age <= old_r) cnt_m_nxt = cnt_m_r + CW'(1);
        else                             cnt_o_nxt = cnt_o_r + CW'(1);
      end
    end

    if (state_r == S_DONE) begin
      out_valid_nxt = 1'b1;
      status_nxt    = STAT_OK;
      slot_nxt      = '0;
      fage_nxt      = '0;
      oy_nxt        = '0;
      om_nxt        = '0;
      oo_nxt        = '0;
      ol_nxt        = '0;
      case (kind_r)
        KIND_INSERT: begin
          if (!free_hit_r) begin
            status_nxt = STAT_FULL;
          end else if (match_hit_r) begin
            status_nxt = STAT_DUPLICATE;
            slot_nxt   = SLOT_W'(match_idx_r);
            fage_nxt   = match_age_r;
          end else begin
            slot_nxt = SLOT_W'(free_idx_r);
          end
        end
        KIND_DELETE, KIND_LOOKUP: begin
          if (!match_hit_r) begin
            status_nxt = STAT_NOT_FOUND;
          end else begin
            slot_nxt = SLOT_W'(match_idx_r);
            if (kind_r == KIND_LOOKUP) fage_nxt = match_age_r;
          end
        end
        KIND_HIST: begin
          oy_nxt = CNT_W'(cnt_y_r);
          om_nxt = CNT_W'(cnt_m_r);
          oo_nxt = CNT_W'(cnt_o_r);
          ol_nxt = CNT_W'(largest);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      young_r     <= YOUNG_LIMIT_RST;
      old_r       <= OLD_LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
      young_r     <= young_nxt;
      old_r       <= old_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    key_r       <= key_nxt;
    age_r       <= age_nxt;
    free_hit_r  <= free_hit_nxt;
    free_idx_r  <= free_idx_nxt;
    match_hit_r <= match_hit_nxt;
    match_idx_r <= match_idx_nxt;
    match_age_r <= match_age_nxt;
    cnt_y_r     <= cnt_y_nxt;
    cnt_m_r     <= cnt_m_nxt;
    cnt_o_r     <= cnt_o_nxt;
    status_r    <= status_nxt;
    slot_r      <= slot_nxt;
    fage_r      <= fage_nxt;
    oy_r        <= oy_nxt;
    om_r        <= om_nxt;
    oo_r        <= oo_nxt;
    ol_r        <= ol_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_slot          = slot_r;
  assign out_found_age     = fage_r;
  assign out_count_young   = oy_r;
  assign out_count_middle  = om_r;
  assign out_count_old     = oo_r;
  assign out_count_largest = ol_r;

endmodule

FILE: rtl/krt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_checker
// Port-level checks of the keyed record table, bound to the top level.
// ----------------------------------------------------------------------------
module krt_checker
  import krt_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_valid,
  input logic [1:0]           out_status,
  input logic [SLOT_W-1:0]    out_slot,
  input logic [AGE_W-1:0]     out_found_age,
  input logic [CNT_W-1:0]     out_count_young,
  input logic [CNT_W-1:0]     out_count_middle,
  input logic [CNT_W-1:0]     out_count_old,
  input logic [CNT_W-1:0]     out_count_largest
);

  // one result per transaction, never two strobes in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // an accepted transaction keeps the unit busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accept");

  // the result only shows once the unit has gone idle
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_FULL) |-> (out_slot == '0 && out_found_age == '0))
    else $error("full status with slot or age");

  a_largest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_count_largest >= out_count_young &&
                   out_count_largest >= out_count_middle &&
                   out_count_largest >= out_count_old))
    else $error("largest count below a band count");

endmodule

bind keyed_record_table_unit krt_checker u_krt_checker (.*);
